FILE: rtl/core/rebs_pkg.sv
`timescale 1ns / 1ps
package rebs_pkg;

  localparam int MAX_POINTS_DEF    = 1024;
  localparam int ANGLE_COUNT_DEF   = 18;
  localparam int BINS_PER_AXIS_DEF = 75;
  localparam int CODE_BITS_DEF     = 2700;

  localparam int COORD_W  = 12;
  localparam int EXT_W    = 14;
  localparam int TRIG_W   = 16;
  localparam int BIN_WIDTH = 10;
  localparam int WORD_W   = 64;
  localparam int WIDX_W   = 6;
  localparam int TRIG_ENTRIES = 36;

  typedef enum logic [1:0] {
    CMD_POINT  = 2'd0,
    CMD_END    = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_BINS,
    ST_EMIT
  } state_t;

  function automatic logic signed [TRIG_W-1:0] cos_q14(input logic [5:0] k);
    logic signed [TRIG_W-1:0] v;
    unique case (k)
      6'd0: v = 16384;  6'd1: v = 16135;  6'd2: v = 15396;  6'd3: v = 14189;
      6'd4: v = 12551;  6'd5: v = 10531;  6'd6: v = 8192;   6'd7: v = 5604;
      6'd8: v = 2845;   6'd9: v = 0;      6'd10: v = -2845; 6'd11: v = -5604;
      6'd12: v = -8192; 6'd13: v = -10531; 6'd14: v = -12551; 6'd15: v = -14189;
      6'd16: v = -15396; 6'd17: v = -16135; 6'd18: v = -16384; 6'd19: v = -16135;
      6'd20: v = -15396; 6'd21: v = -14189; 6'd22: v = -12551; 6'd23: v = -10531;
      6'd24: v = -8192; 6'd25: v = -5604; 6'd26: v = -2845; 6'd27: v = 0;
      6'd28: v = 2845;  6'd29: v = 5604;  6'd30: v = 8192;  6'd31: v = 10531;
      6'd32: v = 12551; 6'd33: v = 14189; 6'd34: v = 15396; 6'd35: v = 16135;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [TRIG_W-1:0] sin_q14(input logic [5:0] k);
    logic [5:0] j;
    j = (k >= 6'd9) ? k - 6'd9 : k + 6'd27;
    return cos_q14(j);
  endfunction

endpackage

FILE: rtl/core/rebs_rotator.sv
`timescale 1ns / 1ps
module rebs_rotator (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [rebs_pkg::EXT_W-1:0] d_a,
  input  logic signed [rebs_pkg::EXT_W-1:0] d_b,
  input  logic signed [rebs_pkg::EXT_W-1:0] ctr,
  input  logic signed [rebs_pkg::TRIG_W-1:0] c,
  input  logic signed [rebs_pkg::TRIG_W-1:0] s,
  input  logic                              neg,
  output logic signed [rebs_pkg::EXT_W-1:0] r
);
  import rebs_pkg::*;

  // r = ctr + rnd((d_a*c -/+ d_b*s) / 2^14), one product pair registered
  logic signed [31:0] pa, pb;
  logic signed [EXT_W-1:0] ctr_q;
  logic neg_q;
  logic signed [32:0] sum;
  logic [32:0] mag;
  logic [18:0] q;

  always_ff @(posedge clk) begin
    if (en) begin
      pa    <= 32'(d_a) * 32'(c);
      pb    <= 32'(d_b) * 32'(s);
      ctr_q <= ctr;
      neg_q <= neg;
    end
  end

  always_comb begin
    sum = neg_q ? (33'(pa) - 33'(pb)) : (33'(pa) + 33'(pb));
    mag = sum[32] ? 33'(-sum) : sum;
    q   = 19'((mag + 33'd8192) >> 14);
    r   = sum[32] ? EXT_W'(ctr_q - $signed(EXT_W'(q))) : EXT_W'(ctr_q + $signed(EXT_W'(q)));
  end

endmodule

FILE: rtl/core/rotated_extent_bit_signature_unit.sv
`timescale 1ns / 1ps
// channel   signals                                  transfer
// command   start, cmd, point_x, point_y, busy       start && !busy
// result    valid, code_word, word_index, last_word  valid (one cycle)
// a point is taken while idle; an end of contour holds busy while it walks the n
// buffered points: per point one store read, 2*ANGLE_COUNT issues to the one shared
// rotator (one axis per cycle), one retire; a finish adds that walk, then a pass
// over 2*ANGLE_COUNT*BINS_PER_AXIS bins, then the code words in order;
// rst is synchronous and clears all control state
// the result side cannot stall: each word is shown for exactly one cycle
module rotated_extent_bit_signature_unit #(
  parameter int MAX_POINTS    = rebs_pkg::MAX_POINTS_DEF,
  parameter int ANGLE_COUNT   = rebs_pkg::ANGLE_COUNT_DEF,
  parameter int BINS_PER_AXIS = rebs_pkg::BINS_PER_AXIS_DEF,
  parameter int CODE_BITS     = rebs_pkg::CODE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [1:0]                      cmd,
  input  logic [rebs_pkg::COORD_W-1:0]    point_x,
  input  logic [rebs_pkg::COORD_W-1:0]    point_y,
  output logic                            busy,
  output logic                            valid,
  output logic [rebs_pkg::WORD_W-1:0]     code_word,
  output logic [rebs_pkg::WIDX_W-1:0]     word_index,
  output logic                            last_word
);
  import rebs_pkg::*;

  localparam int PA_W  = $clog2(MAX_POINTS);
  localparam int PC_W  = $clog2(MAX_POINTS + 1);
  localparam int AN_W  = (ANGLE_COUNT > 1) ? $clog2(ANGLE_COUNT) : 1;
  localparam int BIN_W = $clog2(BINS_PER_AXIS + 1);
  localparam int WORDS = (CODE_BITS + WORD_W - 1) / WORD_W;
  localparam int CB_W  = $clog2(CODE_BITS);
  localparam int CODE_PAD = WORDS * WORD_W;
  // divide by ten as multiply and shift, exact for values below 2^16
  localparam int DIV10_SH = 19;
  localparam int MUL_W    = EXT_W + 17;
  localparam logic [MUL_W-1:0] DIV10_MUL = MUL_W'(((1 << DIV10_SH) + BIN_WIDTH - 1) / BIN_WIDTH);

  state_t state, state_next;

  logic [2*COORD_W-1:0] mem [MAX_POINTS];
  logic [2*COORD_W-1:0] rd;
  logic [PC_W-1:0] point_count;
  logic [COORD_W-1:0] bminx, bmaxx, bminy, bmaxy;
  logic signed [EXT_W-1:0] eminx [ANGLE_COUNT];
  logic signed [EXT_W-1:0] emaxx [ANGLE_COUNT];
  logic signed [EXT_W-1:0] eminy [ANGLE_COUNT];
  logic signed [EXT_W-1:0] emaxy [ANGLE_COUNT];
  logic image_has_points, finish_pending;
  logic [CODE_PAD-1:0] code;

  // rotation walk: read point j, then issue 2*ANGLE_COUNT axis ops
  logic [PC_W-1:0] j;
  logic [AN_W-1:0] ang;
  logic axis, rd_ok, issue, iss_v;
  logic [AN_W-1:0] iss_ang;
  logic iss_axis;
  logic signed [EXT_W-1:0] cx, cy, dx, dy, rr;
  logic [COORD_W:0] sx, sy;

  // bin walk
  logic [AN_W-1:0] b_ang;
  logic b_axis;
  logic [BIN_W-1:0] b_i;
  logic signed [EXT_W-1:0] lo, hi;
  logic [EXT_W-1:0] lo_c, hi_c, lo_p, hi_p;
  logic [MUL_W-1:0] lo_m, hi_m;
  logic [BIN_W+CB_W:0] bitpos;
  logic [WIDX_W-1:0] w;

  always_comb begin
    sx = {1'b0, bminx} + {1'b0, bmaxx};
    sy = {1'b0, bminy} + {1'b0, bmaxy};
    cx = EXT_W'($signed({1'b0, sx[COORD_W:1]}));
    cy = EXT_W'($signed({1'b0, sy[COORD_W:1]}));
    dx = EXT_W'($signed({1'b0, rd[2*COORD_W-1:COORD_W]})) - cx;
    dy = EXT_W'($signed({1'b0, rd[COORD_W-1:0]})) - cy;
  end

  rebs_rotator u_rot (
    .clk (clk),
    .en  (issue),
    .d_a (axis ? dy : dx),
    .d_b (axis ? dx : dy),
    .ctr (axis ? cy : cx),
    .c   (cos_q14(6'(ang))),
    .s   (sin_q14(6'(ang))),
    .neg (!axis),
    .r   (rr)
  );

  assign issue = (state == ST_ROT) && rd_ok;
  wire walk_done = (state == ST_ROT) && !rd_ok && !iss_v && (j == point_count);
  wire seq_last  = (ang == AN_W'(ANGLE_COUNT - 1)) && axis;

  always_comb begin
    lo   = b_axis ? eminy[b_ang] : eminx[b_ang];
    hi   = b_axis ? emaxy[b_ang] : emaxx[b_ang];
    lo_c = lo[EXT_W-1] ? '0 : $unsigned(lo);
    hi_c = hi[EXT_W-1] ? '0 : $unsigned(hi);
    lo_m = MUL_W'(lo_c) * DIV10_MUL;
    hi_m = MUL_W'(hi_c) * DIV10_MUL;
    lo_p = EXT_W'(lo_m >> DIV10_SH);
    hi_p = EXT_W'(hi_m >> DIV10_SH);
    bitpos = (BIN_W+CB_W+1)'(b_i) + (BIN_W+CB_W+1)'(BINS_PER_AXIS) * b_axis
           + (BIN_W+CB_W+1)'(2 * BINS_PER_AXIS) * b_ang;
  end

  wire b_end = (b_i == BIN_W'(BINS_PER_AXIS - 1));
  wire b_last = b_end && b_axis && (b_ang == AN_W'(ANGLE_COUNT - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) begin
        if (cmd == CMD_END || cmd == CMD_FINISH) state_next = ST_ROT;
      end
      ST_ROT: if (walk_done) state_next = finish_pending ? ST_BINS : ST_IDLE;
      ST_BINS: if (b_last) state_next = ST_EMIT;
      ST_EMIT: if (w == WIDX_W'(WORDS - 1)) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy       = (state != ST_IDLE);
    valid      = (state == ST_EMIT);
    word_index = w;
    last_word  = (w == WIDX_W'(WORDS - 1));
    code_word  = code[WORD_W*w +: WORD_W];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (!busy && start && cmd == CMD_POINT && point_count != PC_W'(MAX_POINTS))
      mem[point_count[PA_W-1:0]] <= {point_x, point_y};
    if (!rd_ok) rd <= mem[j[PA_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count      <= '0;
      image_has_points <= 1'b0;
      finish_pending   <= 1'b0;
      rd_ok <= 1'b0;
      iss_v <= 1'b0;
      j <= '0; ang <= '0; axis <= 1'b0;
      b_ang <= '0; b_axis <= 1'b0; b_i <= '0; w <= '0;
    end else begin
      iss_v    <= issue;
      iss_ang  <= ang;
      iss_axis <= axis;
      unique case (state)
        ST_IDLE: if (start) begin
          if (cmd == CMD_POINT && point_count != PC_W'(MAX_POINTS)) begin
            if (point_count == '0) begin
              bminx <= point_x; bmaxx <= point_x; bminy <= point_y; bmaxy <= point_y;
            end else begin
              if (point_x < bminx) bminx <= point_x;
              if (point_x > bmaxx) bmaxx <= point_x;
              if (point_y < bminy) bminy <= point_y;
              if (point_y > bmaxy) bmaxy <= point_y;
            end
            point_count <= point_count + 1'b1;
          end
          if (cmd == CMD_END || cmd == CMD_FINISH) begin
            finish_pending <= (cmd == CMD_FINISH);
            j <= '0; ang <= '0; axis <= 1'b0; rd_ok <= 1'b0;
            code <= '0;
            b_ang <= '0; b_axis <= 1'b0; b_i <= '0; w <= '0;
          end
        end
        ST_ROT: begin
          if (!rd_ok) begin
            if (j != point_count && !iss_v) begin
              rd_ok <= 1'b1;
              j <= j + 1'b1;
            end
          end else begin
            axis <= !axis;
            if (seq_last) begin
              rd_ok <= 1'b0;
              ang <= '0;
            end else if (axis) begin
              ang <= ang + 1'b1;
            end
          end
          if (iss_v) begin
            if (!iss_axis) begin
              if (!image_has_points || rr < eminx[iss_ang]) eminx[iss_ang] <= rr;
              if (!image_has_points || rr > emaxx[iss_ang]) emaxx[iss_ang] <= rr;
            end else begin
              if (!image_has_points || rr < eminy[iss_ang]) eminy[iss_ang] <= rr;
              if (!image_has_points || rr > emaxy[iss_ang]) emaxy[iss_ang] <= rr;
              if (iss_ang == AN_W'(ANGLE_COUNT - 1)) image_has_points <= 1'b1;
            end
          end
          if (walk_done) point_count <= '0;
        end
        ST_BINS: begin
          if (image_has_points && EXT_W'(b_i) >= lo_p && EXT_W'(b_i) < hi_p
              && bitpos < (BIN_W+CB_W+1)'(CODE_BITS))
            code[bitpos[CB_W-1:0]] <= 1'b1;
          b_i <= b_end ? '0 : b_i + 1'b1;
          if (b_end) begin
            b_axis <= !b_axis;
            if (b_axis) b_ang <= b_ang + 1'b1;
          end
        end
        ST_EMIT: begin
          w <= w + 1'b1;
          if (w == WIDX_W'(WORDS - 1)) image_has_points <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import rebs_pkg::*;

  localparam int NPTS   = MAX_POINTS_DEF;
  localparam int NANG   = ANGLE_COUNT_DEF;
  localparam int NBINS  = BINS_PER_AXIS_DEF;
  localparam int NBITS  = CODE_BITS_DEF;
  localparam int NWORDS = (NBITS + WORD_W - 1) / WORD_W;

  typedef struct {
    cmd_t             op;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    bit               drain;
  } contour_cmd_t;

  typedef struct {
    logic [WORD_W-1:0] bits;
    logic [WIDX_W-1:0] idx;
    logic              last;
  } sig_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] cmd = CMD_NONE;
  logic [COORD_W-1:0] point_x = '0;
  logic [COORD_W-1:0] point_y = '0;
  logic busy, valid, last_word;
  logic [WORD_W-1:0] code_word;
  logic [WIDX_W-1:0] word_index;

  rotated_extent_bit_signature_unit u_top (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .point_x(point_x),
    .point_y(point_y), .busy(busy), .valid(valid), .code_word(code_word),
    .word_index(word_index), .last_word(last_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  contour_cmd_t pending[$];
  sig_word_t    sig_words[$];
  int errors = 0;
  int n_points = 0, n_closes = 0, n_images = 0, n_words = 0;

  // predictor state
  logic [COORD_W-1:0] buf_x[NPTS];
  logic [COORD_W-1:0] buf_y[NPTS];
  int buf_count = 0;
  int bx_lo, bx_hi, by_lo, by_hi;
  int ex_lo[NANG], ex_hi[NANG], ey_lo[NANG], ey_hi[NANG];
  bit image_live = 0;

  function automatic int trig(int k, bit want_sin);
    int c[36] = '{16384, 16135, 15396, 14189, 12551, 10531, 8192, 5604, 2845,
      0, -2845, -5604, -8192, -10531, -12551, -14189, -15396, -16135,
      -16384, -16135, -15396, -14189, -12551, -10531, -8192, -5604, -2845,
      0, 2845, 5604, 8192, 10531, 12551, 14189, 15396, 16135};
    return want_sin ? c[(k + 27) % 36] : c[k];
  endfunction

  function automatic int q14_round(longint p);
    if (p >= 0) return int'((p + 8192) >>> 14);
    return -int'((-p + 8192) >>> 14);
  endfunction

  function automatic void sweep_contour();
    int cx, cy, dx, dy, rx, ry, cs, sn;
    if (buf_count == 0) return;
    cx = (bx_lo + bx_hi) >>> 1;
    cy = (by_lo + by_hi) >>> 1;
    for (int j = 0; j < buf_count; j++) begin
      dx = int'(buf_x[j]) - cx;
      dy = int'(buf_y[j]) - cy;
      for (int a = 0; a < NANG; a++) begin
        cs = trig(a, 0);
        sn = trig(a, 1);
        rx = cx + q14_round(longint'(dx) * cs - longint'(dy) * sn);
        ry = cy + q14_round(longint'(dy) * cs + longint'(dx) * sn);
        if (!image_live) begin
          ex_lo[a] = rx; ex_hi[a] = rx; ey_lo[a] = ry; ey_hi[a] = ry;
        end else begin
          if (rx < ex_lo[a]) ex_lo[a] = rx;
          if (rx > ex_hi[a]) ex_hi[a] = rx;
          if (ry < ey_lo[a]) ey_lo[a] = ry;
          if (ry > ey_hi[a]) ey_hi[a] = ry;
        end
      end
      image_live = 1;
    end
    buf_count = 0;
    n_closes++;
  endfunction

  function automatic void mark_bins(ref logic [NWORDS*WORD_W-1:0] sig, input int lo,
                                    input int hi, input int base);
    for (int i = (lo > 0 ? lo : 0) / BIN_WIDTH; i < hi / BIN_WIDTH && i < NBINS; i++)
      if (base + i < NBITS) sig[base + i] = 1'b1;
  endfunction

  function automatic void apply_command(contour_cmd_t it);
    logic [NWORDS*WORD_W-1:0] sig;
    sig_word_t w;
    case (it.op)
      CMD_POINT: begin
        if (buf_count < NPTS) begin
          if (buf_count == 0) begin
            bx_lo = it.x; bx_hi = it.x; by_lo = it.y; by_hi = it.y;
          end else begin
            if (it.x < bx_lo) bx_lo = it.x;
            if (it.x > bx_hi) bx_hi = it.x;
            if (it.y < by_lo) by_lo = it.y;
            if (it.y > by_hi) by_hi = it.y;
          end
          buf_x[buf_count] = it.x;
          buf_y[buf_count] = it.y;
          buf_count++;
        end
        n_points++;
      end
      CMD_END: sweep_contour();
      CMD_FINISH: begin
        sweep_contour();
        sig = '0;
        if (image_live)
          for (int a = 0; a < NANG; a++) begin
            mark_bins(sig, ex_lo[a], ex_hi[a], 2 * NBINS * a);
            mark_bins(sig, ey_lo[a], ey_hi[a], 2 * NBINS * a + NBINS);
          end
        for (int k = 0; k < NWORDS; k++) begin
          w.bits = sig[k*WORD_W +: WORD_W];
          w.idx  = k[WIDX_W-1:0];
          w.last = (k == NWORDS - 1);
          sig_words.insert(sig_words.size(), w);
        end
        image_live = 0;
        buf_count = 0;
        n_images++;
      end
      default: ;
    endcase
  endfunction

  // driver
  contour_cmd_t cur;
  logic xfer = 1'b0;
  int gap = 0;

  always @(posedge clk) begin
    xfer <= start && !busy && !rst;
    if (start && !busy && !rst) apply_command(cur);
  end

  always @(negedge clk) begin
    if (rst || (start && !xfer)) begin
    end else if (gap > 0) begin
      gap <= gap - 1;
      start <= 1'b0;
    end else if (pending.size() > 0 && !(pending[0].drain && sig_words.size() > 0)) begin
      cur = pending.pop_front();
      cmd <= cur.op;
      point_x <= cur.x;
      point_y <= cur.y;
      start <= 1'b1;
      gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 12) : 0;
    end else begin
      start <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    sig_word_t e;
    if (valid && !rst) begin
      n_words++;
      if (sig_words.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word idx=%0d bits=%h", word_index, code_word);
      end else begin
        e = sig_words.pop_front();
        if (e.bits !== code_word || e.idx !== word_index || e.last !== last_word) begin
          errors++;
          if (errors <= 10)
            $display("word mismatch exp idx=%0d last=%b bits=%h got idx=%0d last=%b bits=%h",
                     e.idx, e.last, e.bits, word_index, last_word, code_word);
        end
      end
    end
  end

  task automatic add(cmd_t op, int x = 0, int y = 0, bit drain = 0);
    contour_cmd_t it;
    it.op = op;
    it.x = x[COORD_W-1:0];
    it.y = y[COORD_W-1:0];
    it.drain = drain;
    pending.insert(pending.size(), it);
  endtask

  initial begin
    int lo, span, ncont, npts, total;
    bit wide;
    // directed: empty image, extremes, empty contour, unused command
    add(CMD_FINISH);
    add(CMD_END, 0, 0, 1);
    add(CMD_NONE, 4095, 4095);
    add(CMD_POINT, 0, 0);
    add(CMD_POINT, 4095, 4095);
    add(CMD_POINT, 4095, 0);
    add(CMD_END);
    add(CMD_END);
    add(CMD_POINT, 0, 4095);
    add(CMD_POINT, 2730, 1365);
    add(CMD_FINISH);
    add(CMD_POINT, 5, 7, 1);
    add(CMD_POINT, 300, 40);
    add(CMD_POINT, 120, 700);
    add(CMD_FINISH);
    add(CMD_POINT, 2048, 2048);
    add(CMD_END);
    add(CMD_FINISH);
    // random images of well-formed contours, with some noise
    total = 18;
    while (total < 400) begin
      ncont = $urandom_range(0, 4);
      for (int c = 0; c < ncont; c++) begin
        npts = $urandom_range(0, 10);
        wide = ($urandom_range(0, 4) == 0);
        span = wide ? 4095 : $urandom_range(1, 300);
        lo = $urandom_range(0, 4095 - span);
        for (int p = 0; p < npts; p++) begin
          add(CMD_POINT, lo + $urandom_range(0, span), lo + $urandom_range(0, span));
          total++;
        end
        if ($urandom_range(0, 9) == 0) begin
          add(CMD_NONE, $urandom, $urandom);
          total++;
        end
        if (c != ncont - 1 || $urandom_range(0, 3) != 0) begin
          add(CMD_END);
          total++;
        end
      end
      add(CMD_FINISH, 0, 0, $urandom_range(0, 5) == 0);
      total++;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (pending.size() > 0 || start) @(posedge clk);
    while (sig_words.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d points, %0d closed contours, %0d images", n_points, n_closes, n_images);
    $display("checked %0d signature words, %0d mismatches", n_words, errors);
    if (errors == 0 && sig_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: rotated_extent_bit_signature_unit.f
rtl/core/rebs_pkg.sv
rtl/core/rebs_rotator.sv
rtl/core/rotated_extent_bit_signature_unit.sv
tb/tb.sv
